@@ hdl/welf_pkg.sv @@
// Shared types and constants for the windowed extremum level finder.
package welf_pkg;

   // Reset window length: 9 points a day times 5 days (week resolution)
   localparam logic [7:0] WEEK_WINDOW = 8'(9 * 5);

   // CSR word index of the window length register
   localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

   // Level kinds
   localparam logic KIND_SUPPORT    = 1'b0;
   localparam logic KIND_RESISTANCE = 1'b1;

   // Result slots of one item, in emission order
   localparam logic [1:0] SLOT_PEND_MIN = 2'd0;
   localparam logic [1:0] SLOT_PEND_MAX = 2'd1;
   localparam logic [1:0] SLOT_WIN_MIN  = 2'd2;
   localparam logic [1:0] SLOT_WIN_MAX  = 2'd3;

   // What to do with a held level once the next price is known
   typedef enum logic [1:0] {
      DEC_DROP    = 2'd0,
      DEC_EMIT    = 2'd1,
      DEC_IF_NEXT = 2'd2
   } decision_type;

   // One input item
   typedef struct packed {
      logic        end_of_series;
      logic [39:0] timestamp;
      logic [31:0] price;
   } item_type;

   // One level payload
   typedef struct packed {
      logic [39:0] level_time;
      logic [31:0] level_price;
   } level_type;

   // All results caused by one item, one slot per possible result
   typedef struct packed {
      logic [3:0]            mask;
      level_type [3:0]       level;
   } bundle_type;

endpackage

@@ hdl/welf_in_reg.sv @@
// Input register stage: holds one accepted item until the level logic takes it.
module welf_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  welf_pkg::item_type req_item,
   output logic               item_valid_o,
   output welf_pkg::item_type item_o,
   input  logic               take_i
);
   import welf_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // Free when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || take_i;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (take_i) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid_o = valid_ff;
   assign item_o       = item_ff;

endmodule

@@ hdl/welf_level_calc.sv @@
// Window tracking: running min/max, end-of-window decisions and held levels.
module welf_level_calc #(
   parameter int POSITION_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           window_length_i,
   input  logic                 item_valid_i,
   input  welf_pkg::item_type   item_i,
   input  logic                 queue_free_i,
   output logic                 take_o,
   output logic                 load_o,
   output welf_pkg::bundle_type bundle_o
);
   import welf_pkg::*;

   localparam int CMP_W = ((POSITION_BITS > 8) ? POSITION_BITS : 8) + 1;

   // State registers
   logic [31:0]              prev_price_ff;
   logic                     has_prev_ff, has_prev_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [31:0]              min_price_ff, min_price_in;
   logic [39:0]              min_time_ff, min_time_in;
   logic [POSITION_BITS-1:0] min_pos_ff, min_pos_in;
   logic [31:0]              max_price_ff, max_price_in;
   logic [39:0]              max_time_ff, max_time_in;
   logic [POSITION_BITS-1:0] max_pos_ff, max_pos_in;
   logic                     start_has_prior_ff, start_has_prior_in;
   logic [31:0]              start_prior_ff, start_prior_in;
   logic [31:0]              pmin_price_ff;
   logic [39:0]              pmin_time_ff;
   decision_type             pmin_dec_ff, pmin_dec_in;
   logic [31:0]              pmax_price_ff;
   logic [39:0]              pmax_time_ff;
   decision_type             pmax_dec_ff, pmax_dec_in;

   logic              pos_zero, window_end;
   logic [CMP_W-1:0]  pos_count;
   logic              emit_pmin, emit_pmax, emit_wmin, emit_wmax;
   logic              min_first, min_last, max_first, max_last;
   decision_type      dmin, dmax;
   logic [3:0]        mask;

   assign pos_zero  = (pos_ff == '0);
   assign pos_count = CMP_W'(pos_ff) + CMP_W'(1);
   assign window_end = (pos_count >= CMP_W'(window_length_i)) ||
                       (pos_ff == {POSITION_BITS{1'b1}}) || item_i.end_of_series;

   // Held levels of the previous window, resolved by this price
   assign emit_pmin = (pmin_dec_ff == DEC_EMIT) ||
                      ((pmin_dec_ff == DEC_IF_NEXT) && (item_i.price > pmin_price_ff));
   assign emit_pmax = (pmax_dec_ff == DEC_EMIT) ||
                      ((pmax_dec_ff == DEC_IF_NEXT) && (item_i.price < pmax_price_ff));

   // Running extremes; min keeps the first tie, max the last
   always_comb begin
      min_price_in = min_price_ff;
      min_time_in  = min_time_ff;
      min_pos_in   = min_pos_ff;
      max_price_in = max_price_ff;
      max_time_in  = max_time_ff;
      max_pos_in   = max_pos_ff;
      start_has_prior_in = start_has_prior_ff;
      start_prior_in     = start_prior_ff;
      if (pos_zero) begin
         start_has_prior_in = has_prev_ff;
         start_prior_in     = prev_price_ff;
         min_price_in = item_i.price;
         min_time_in  = item_i.timestamp;
         min_pos_in   = '0;
         max_price_in = item_i.price;
         max_time_in  = item_i.timestamp;
         max_pos_in   = '0;
      end else begin
         if (item_i.price < min_price_ff) begin
            min_price_in = item_i.price;
            min_time_in  = item_i.timestamp;
            min_pos_in   = pos_ff;
         end
         if (item_i.price >= max_price_ff) begin
            max_price_in = item_i.price;
            max_time_in  = item_i.timestamp;
            max_pos_in   = pos_ff;
         end
      end
   end

   // End-of-window decisions
   assign min_first = (min_pos_in == '0);
   assign min_last  = (min_pos_in == pos_ff);
   assign max_first = (max_pos_in == '0);
   assign max_last  = (max_pos_in == pos_ff);

   always_comb begin
      priority if (!min_first && !min_last) begin
         dmin = DEC_EMIT;
      end else if (min_first && start_has_prior_in && (start_prior_in > min_price_in)) begin
         dmin = DEC_EMIT;
      end else if (min_last) begin
         dmin = DEC_IF_NEXT;
      end else begin
         dmin = DEC_DROP;
      end
      priority if (!max_first && !max_last) begin
         dmax = DEC_EMIT;
      end else if (max_first && start_has_prior_in && (start_prior_in < max_price_in)) begin
         dmax = DEC_EMIT;
      end else if (max_last) begin
         dmax = DEC_IF_NEXT;
      end else begin
         dmax = DEC_DROP;
      end
   end

   // A series end has no follower: only firm decisions go out now
   assign emit_wmin = item_i.end_of_series && (dmin == DEC_EMIT);
   assign emit_wmax = item_i.end_of_series && (dmax == DEC_EMIT);

   assign mask = {emit_wmax, emit_wmin, emit_pmax, emit_pmin};

   // Items without results never wait for the output side
   assign take_o = item_valid_i && ((mask == 4'b0000) || queue_free_i);
   assign load_o = take_o && (mask != 4'b0000);

   always_comb begin
      bundle_o.mask = mask;
      bundle_o.level[SLOT_PEND_MIN].level_price = pmin_price_ff;
      bundle_o.level[SLOT_PEND_MIN].level_time  = pmin_time_ff;
      bundle_o.level[SLOT_PEND_MAX].level_price = pmax_price_ff;
      bundle_o.level[SLOT_PEND_MAX].level_time  = pmax_time_ff;
      bundle_o.level[SLOT_WIN_MIN].level_price  = min_price_in;
      bundle_o.level[SLOT_WIN_MIN].level_time   = min_time_in;
      bundle_o.level[SLOT_WIN_MAX].level_price  = max_price_in;
      bundle_o.level[SLOT_WIN_MAX].level_time   = max_time_in;
   end

   // Next control state
   always_comb begin
      pmin_dec_in = DEC_DROP;
      pmax_dec_in = DEC_DROP;
      if (window_end && !item_i.end_of_series) begin
         pmin_dec_in = dmin;
         pmax_dec_in = dmax;
      end
      pos_in      = window_end ? '0 : (pos_ff + POSITION_BITS'(1));
      has_prev_in = !item_i.end_of_series;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_prev_ff <= 1'b0;
         pos_ff      <= '0;
         pmin_dec_ff <= DEC_DROP;
         pmax_dec_ff <= DEC_DROP;
      end else if (take_o) begin
         has_prev_ff <= has_prev_in;
         pos_ff      <= pos_in;
         pmin_dec_ff <= pmin_dec_in;
         pmax_dec_ff <= pmax_dec_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      if (take_o) begin
         prev_price_ff      <= item_i.price;
         min_price_ff       <= min_price_in;
         min_time_ff        <= min_time_in;
         min_pos_ff         <= min_pos_in;
         max_price_ff       <= max_price_in;
         max_time_ff        <= max_time_in;
         max_pos_ff         <= max_pos_in;
         start_has_prior_ff <= start_has_prior_in;
         start_prior_ff     <= start_prior_in;
         if (window_end) begin
            pmin_price_ff <= min_price_in;
            pmin_time_ff  <= min_time_in;
            pmax_price_ff <= max_price_in;
            pmax_time_ff  <= max_time_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_window_restart: assert property (@(posedge clock) disable iff (reset)
      take_o && window_end |=> pos_ff == '0)
      else $error("position not cleared after window end");
   a_series_end_clears: assert property (@(posedge clock) disable iff (reset)
      take_o && item_i.end_of_series |=>
         !has_prev_ff && pmin_dec_ff == DEC_DROP && pmax_dec_ff == DEC_DROP)
      else $error("state left over after series end");
   a_mid_window_no_pending: assert property (@(posedge clock) disable iff (reset)
      take_o && !window_end |=> pmin_dec_ff == DEC_DROP && pmax_dec_ff == DEC_DROP)
      else $error("held level created inside a window");
`endif

endmodule

@@ hdl/welf_out_queue.sv @@
// Result register: holds an item's levels, one out per cycle unless stalled.
module welf_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_i,
   input  welf_pkg::bundle_type bundle_i,
   output logic                 queue_free_o,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,
   output logic [0:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import welf_pkg::*;

   logic [3:0] mask_ff, mask_in;
   bundle_type bundle_ff;
   logic [1:0] sel;
   logic [3:0] sel_bit;
   level_type  level;
   logic       kind;
   logic       accept;

   // Lowest pending slot goes first
   always_comb begin
      priority if (mask_ff[0]) begin
         sel = SLOT_PEND_MIN;
      end else if (mask_ff[1]) begin
         sel = SLOT_PEND_MAX;
      end else if (mask_ff[2]) begin
         sel = SLOT_WIN_MIN;
      end else begin
         sel = SLOT_WIN_MAX;
      end
   end

   always_comb begin
      unique case (sel)
         SLOT_PEND_MIN, SLOT_WIN_MIN: kind = KIND_SUPPORT;
         default:                     kind = KIND_RESISTANCE;
      endcase
   end

   assign sel_bit = 4'b0001 << sel;
   assign level   = bundle_ff.level[sel];
   assign accept  = rsp_tvalid && rsp_tready;

   assign rsp_tvalid   = (mask_ff != 4'b0000);
   assign rsp_tdata    = {level.level_time, level.level_price};
   assign rsp_tuser[0] = kind;
   assign rsp_tlast    = ((mask_ff & ~sel_bit) == 4'b0000);

   // Free when empty or when the last level leaves this cycle
   assign queue_free_o = !rsp_tvalid || (accept && rsp_tlast);

   always_comb begin
      mask_in = mask_ff;
      if (load_i) begin
         mask_in = bundle_i.mask;
      end else if (accept) begin
         mask_in = mask_ff & ~sel_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 4'b0000;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_i) begin
         bundle_ff <= bundle_i;
      end
   end

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_i |-> queue_free_o)
      else $error("levels loaded over undelivered levels");
   a_load_not_empty: assert property (@(posedge clock) disable iff (reset)
      load_i |=> rsp_tvalid)
      else $error("empty level set loaded");
   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("level changed while stalled");
`endif

endmodule

@@ hdl/windowed_extremum_level_finder_core.sv @@
// Top level of the windowed extremum level finder: CSR, input stage, level logic, output.
// Flow: an accepted item waits in the input register until the level logic takes it; its
//   levels are then loaded into the result register and offered on rsp from then on.
// Throughput: one item per cycle while the result register is free; an item with k levels
//   drains them one per cycle unless rsp stalls; items without levels pass freely.
// Reset (synchronous, active high): window length back to 45, no previous point,
//   position zero, nothing held, input and output registers empty.
module windowed_extremum_level_finder_core #(
   parameter int POSITION_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [31:0] price, [71:32] timestamp
   input  logic        req_tlast,   // end_of_series
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] level_price, [71:32] level_time
   output logic [0:0]  rsp_tuser,   // [0] level_kind
   output logic        rsp_tlast,   // last_of_run
   // Configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import welf_pkg::*;

   logic [7:0] window_length_ff;
   logic       csr_write, csr_hit;
   item_type   req_item, item;
   logic       item_valid, take, load, queue_free;
   bundle_type bundle;

   // Window length register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_WINDOW_LENGTH);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? {24'd0, window_length_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WEEK_WINDOW;
      end else if (csr_write) begin
         window_length_ff <= csr_pwdata[7:0];
      end
   end

   // Unpack the input item
   assign req_item.price         = req_tdata[31:0];
   assign req_item.timestamp     = req_tdata[71:32];
   assign req_item.end_of_series = req_tlast;

   welf_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_item     (req_item),
      .item_valid_o (item_valid),
      .item_o       (item),
      .take_i       (take)
   );

   welf_level_calc #(
      .POSITION_BITS (POSITION_BITS)
   ) u_level_calc (
      .clock           (clock),
      .reset           (reset),
      .window_length_i (window_length_ff),
      .item_valid_i    (item_valid),
      .item_i          (item),
      .queue_free_i    (queue_free),
      .take_o          (take),
      .load_o          (load),
      .bundle_o        (bundle)
   );

   welf_out_queue u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .load_i       (load),
      .bundle_i     (bundle),
      .queue_free_o (queue_free),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
